// File: hw/rtl/uef_pkg.sv
`timescale 1ns / 1ps

package uef_pkg;

  localparam int WIN_DEPTH   = 18;
  localparam int OPEN_LEN    = 18;
  localparam int CLOSE_LEN   = 19;
  localparam int NEEDLE_LEN  = 18;
  localparam int MIN_CAP     = 64;
  localparam int BODY_MARGIN = 21;
  localparam int IDX_W       = 5;

  typedef logic [IDX_W-1:0] tag_idx_t;

  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_AMP    = 8'h26;

  localparam logic [7:0] UTF_E2     = 8'hE2;
  localparam logic [7:0] UTF_EF     = 8'hEF;
  localparam logic [7:0] UTF_BB     = 8'hBB;
  localparam logic [7:0] UTF_BF     = 8'hBF;
  localparam logic [7:0] UTF_80     = 8'h80;
  localparam logic [7:0] UTF_81     = 8'h81;
  localparam logic [7:0] ZW_LO      = 8'h8B;
  localparam logic [7:0] ZW_HI      = 8'h8F;
  localparam logic [7:0] BIDI_LO    = 8'hAA;
  localparam logic [7:0] BIDI_HI    = 8'hAE;
  localparam logic [7:0] ISO_LO     = 8'hA6;
  localparam logic [7:0] ISO_HI     = 8'hA9;

  // first character in the top byte
  localparam logic [8*NEEDLE_LEN-1:0] NEEDLE   = {"</untrusted", "_input>"};
  localparam logic [8*OPEN_LEN-1:0]   HDR_TEXT = {"<untrusted", "_input>", BYTE_LF};
  localparam logic [8*CLOSE_LEN-1:0]  TRL_TEXT = {BYTE_LF, NEEDLE};

  typedef enum logic [2:0] {
    CMD_LIT,
    CMD_ESC,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_NONE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] total;
  } cmd_t;

  function automatic logic [7:0] open_byte(input tag_idx_t idx);
    return HDR_TEXT[8*(OPEN_LEN-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] close_byte(input tag_idx_t idx);
    return TRL_TEXT[8*(CLOSE_LEN-1-int'(idx)) +: 8];
  endfunction

endpackage

// File: hw/rtl/uef_front.sv
`timescale 1ns / 1ps

module uef_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            in_empty_i,
  input  logic [15:0]     capacity_i,
  output logic            cmd_push_o,
  output uef_pkg::cmd_t   cmd_o,
  input  logic            cmd_full_i
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam int W = uef_pkg::WIN_DEPTH;

  logic [1:0]    state_q, state_d;
  logic [7:0]    win_q [W];
  logic [7:0]    win_d [W];
  logic [4:0]    fill_q, fill_d;
  logic [15:0]   produced_q, produced_d;
  logic          started_q, started_d;
  logic          body_full_q, body_full_d;
  logic          hold_vld_q, hold_vld_d;
  uef_pkg::cmd_t hold_q, hold_d;

  logic          accept, ending, body_ok, small_cap;
  logic [7:0]    view [W];
  logic [7:0]    shift1 [W];
  logic [7:0]    shift3 [W];
  logic [8*W-1:0] view_flat;
  logic [4:0]    rem;
  logic [7:0]    c;
  logic          room, hidden, ctrl, needle_hit, do_decide;
  logic          new_vld;
  uef_pkg::cmd_t new_cmd;

  assign accept    = item_valid_i && (state_q == ST_RUN) && !cmd_full_i;
  assign ending    = in_last_i || in_empty_i;
  assign small_cap = capacity_i < 16'(uef_pkg::MIN_CAP);
  assign item_ready_o = (state_q == ST_RUN) && !cmd_full_i;

  // in steady flow the window holds 17 bytes and the new byte completes it
  always_comb begin
    for (int i = 0; i < W - 1; i++) begin
      view[i] = win_q[i];
    end
    view[W-1] = (state_q == ST_DRAIN) ? win_q[W-1] : in_byte_i;
    for (int i = 0; i < W; i++) begin
      view_flat[8*(W-1-i) +: 8] = view[i];
      shift1[i] = (i + 1 < W) ? view[(i + 1) % W] : view[i];
      shift3[i] = (i + 3 < W) ? view[(i + 3) % W] : view[i];
    end
  end

  assign rem = (state_q == ST_DRAIN) ? fill_q : 5'(W);
  assign c   = view[0];

  assign room = (17'(produced_q) + 17'(uef_pkg::BODY_MARGIN)) < 17'(capacity_i);

  assign hidden = (rem >= 5'd3) && (
      (c == uef_pkg::UTF_E2 && view[1] == uef_pkg::UTF_80 &&
       view[2] >= uef_pkg::ZW_LO && view[2] <= uef_pkg::ZW_HI) ||
      (c == uef_pkg::UTF_E2 && view[1] == uef_pkg::UTF_80 &&
       view[2] >= uef_pkg::BIDI_LO && view[2] <= uef_pkg::BIDI_HI) ||
      (c == uef_pkg::UTF_E2 && view[1] == uef_pkg::UTF_81 &&
       view[2] >= uef_pkg::ISO_LO && view[2] <= uef_pkg::ISO_HI) ||
      (c == uef_pkg::UTF_EF && view[1] == uef_pkg::UTF_BB && view[2] == uef_pkg::UTF_BF));

  assign ctrl = (c < uef_pkg::BYTE_SPACE && c != uef_pkg::BYTE_TAB && c != uef_pkg::BYTE_LF) ||
                (c == uef_pkg::BYTE_DEL);

  assign needle_hit = (rem == 5'(W)) && (view_flat == uef_pkg::NEEDLE);

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    fill_d      = fill_q;
    produced_d  = produced_q;
    started_d   = started_q;
    body_full_d = body_full_q;
    hold_vld_d  = hold_vld_q;
    hold_d      = hold_q;
    cmd_push_o  = 1'b0;
    cmd_o       = '0;
    new_vld     = 1'b0;
    new_cmd     = '0;
    do_decide   = 1'b0;
    body_ok     = 1'b0;

    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (!started_q) begin
            started_d = 1'b1;
            if (small_cap) begin
              body_full_d = 1'b1;
            end else begin
              new_vld      = 1'b1;
              new_cmd.kind = uef_pkg::CMD_OPEN;
              produced_d   = produced_q + 16'(uef_pkg::OPEN_LEN);
            end
          end
          body_ok = !in_empty_i && !body_full_q && !(!started_q && small_cap);
          if (body_ok) begin
            if (!ending && fill_q == 5'(W - 1)) begin
              do_decide = 1'b1;
            end else begin
              win_d[fill_q] = in_byte_i;
              fill_d        = fill_q + 5'd1;
            end
          end
          if (ending) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!cmd_full_i) begin
          if (fill_q != 5'd0 && !body_full_q) begin
            do_decide = 1'b1;
          end else begin
            state_d = ST_FLUSH;
            if (produced_q != 16'd0 &&
                (17'(produced_q) + 17'(uef_pkg::CLOSE_LEN)) < 17'(capacity_i)) begin
              new_vld      = 1'b1;
              new_cmd.kind = uef_pkg::CMD_CLOSE;
              produced_d   = produced_q + 16'(uef_pkg::CLOSE_LEN);
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          if (hold_vld_q) begin
            cmd_o = hold_q;
          end else begin
            cmd_o.kind = uef_pkg::CMD_NONE;
          end
          cmd_o.last  = 1'b1;
          cmd_o.total = produced_q;
          fill_d      = 5'd0;
          produced_d  = 16'd0;
          started_d   = 1'b0;
          body_full_d = 1'b0;
          hold_vld_d  = 1'b0;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    // head decision: truncate, drop a hidden sequence, drop a control byte, escape or copy
    if (do_decide) begin
      if (!room) begin
        body_full_d = 1'b1;
        fill_d      = 5'd0;
      end else if (hidden) begin
        win_d  = shift3;
        fill_d = rem - 5'd3;
      end else begin
        win_d  = shift1;
        fill_d = rem - 5'd1;
        if (!ctrl) begin
          new_vld = 1'b1;
          if (needle_hit) begin
            new_cmd.kind = uef_pkg::CMD_ESC;
            produced_d   = produced_q + 16'd2;
          end else begin
            new_cmd.kind = uef_pkg::CMD_LIT;
            new_cmd.data = c;
            produced_d   = produced_q + 16'd1;
          end
        end
      end
    end

    // within a closing item the newest word is held back so that it can take the last flag
    if (new_vld) begin
      if (state_q == ST_RUN && !ending) begin
        cmd_push_o = 1'b1;
        cmd_o      = new_cmd;
      end else begin
        if (hold_vld_q) begin
          cmd_push_o = 1'b1;
          cmd_o      = hold_q;
        end
        hold_d     = new_cmd;
        hold_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      fill_q      <= 5'd0;
      produced_q  <= 16'd0;
      started_q   <= 1'b0;
      body_full_q <= 1'b0;
      hold_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      produced_q  <= produced_d;
      started_q   <= started_d;
      body_full_q <= body_full_d;
      hold_vld_q  <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    hold_q <= hold_d;
  end

endmodule

// File: hw/rtl/uef_cmd_fifo.sv
`timescale 1ns / 1ps

module uef_cmd_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uef_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output uef_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  uef_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/uef_back.sv
`timescale 1ns / 1ps

module uef_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  uef_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          out_valid_o,
  output logic          out_last_o,
  output logic [15:0]   total_length_o
);

  uef_pkg::tag_idx_t idx_q, idx_d;
  uef_pkg::tag_idx_t last_idx;
  logic              res_vld_q, res_vld_d;
  logic [7:0]        byte_q, byte_d;
  logic              valid_q, last_q;
  logic [15:0]       total_q;
  logic              load, step, is_final;

  assign load     = !res_vld_q || pop_i;
  assign step     = load && !cmd_empty_i;
  assign is_final = idx_q == last_idx;
  assign cmd_pop_o = step && is_final;

  always_comb begin
    unique case (cmd_i.kind)
      uef_pkg::CMD_OPEN: begin
        last_idx = uef_pkg::tag_idx_t'(uef_pkg::OPEN_LEN - 1);
        byte_d   = uef_pkg::open_byte(idx_q);
      end
      uef_pkg::CMD_CLOSE: begin
        last_idx = uef_pkg::tag_idx_t'(uef_pkg::CLOSE_LEN - 1);
        byte_d   = uef_pkg::close_byte(idx_q);
      end
      uef_pkg::CMD_ESC: begin
        last_idx = uef_pkg::tag_idx_t'(1);
        byte_d   = (idx_q == '0) ? uef_pkg::BYTE_BSLASH : uef_pkg::BYTE_AMP;
      end
      uef_pkg::CMD_LIT: begin
        last_idx = '0;
        byte_d   = cmd_i.data;
      end
      default: begin
        last_idx = '0;
        byte_d   = 8'd0;
      end
    endcase
  end

  always_comb begin
    idx_d     = idx_q;
    res_vld_d = res_vld_q;
    if (load) begin
      res_vld_d = !cmd_empty_i;
    end
    if (step) begin
      idx_d = is_final ? '0 : idx_q + uef_pkg::tag_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q  <= byte_d;
      valid_q <= cmd_i.kind != uef_pkg::CMD_NONE;
      last_q  <= cmd_i.last && is_final;
      total_q <= (cmd_i.last && is_final) ? cmd_i.total : 16'd0;
    end
  end

  assign empty_o        = !res_vld_q;
  assign out_byte_o     = byte_q;
  assign out_valid_o    = valid_q;
  assign out_last_o     = last_q;
  assign total_length_o = total_q;

endmodule

// File: hw/rtl/untrusted_text_envelope_filter.sv
// A body word is decided when the word 17 places behind it is taken (or at message end), then
// passes the command queue and the back-end output register. Throughput: one input and one
// result word a cycle while the queue has room and results are popped; the 18-word opening tag
// and 19-word closing tag leave the back end one word a cycle. A closing input word holds off
// input while the rest of the window is decided, one decision a cycle while the queue has room.
// Reset (async, active low) empties the queues and message state; capacity returns to 4096.
`timescale 1ns / 1ps

module untrusted_text_envelope_filter #(
  parameter int CmdDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        in_empty_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        out_last_o,
  output logic [15:0] total_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  logic [15:0]   capacity_q;
  logic          item_ready;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  uef_pkg::cmd_t cmd_in, cmd_head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? {16'd0, capacity_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 16'd4096;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity_q <= pwdata[15:0];
    end
  end

  assign full = !item_ready;

  uef_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (push),
    .item_ready_o (item_ready),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .in_empty_i   (in_empty_i),
    .capacity_i   (capacity_q),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .cmd_full_i   (cmd_full)
  );

  uef_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  uef_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_head),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .out_last_o     (out_last_o),
    .total_length_o (total_length_o)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int WIN_LEN       = 18;
  localparam int TAG_LEN       = 18;
  localparam int MIN_CAPACITY  = 64;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  localparam logic [8*TAG_LEN-1:0] OPEN_TEXT  = {"<untrusted", "_input>", 8'h0A};
  localparam logic [8*TAG_LEN-1:0] CLOSE_TEXT = {"</untrusted", "_input>"};
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AMP    = 8'h26;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic [15:0] total;
  } env_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i = 8'h00;
  logic        in_last_i = 1'b0;
  logic        in_empty_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_valid_o;
  logic        out_last_o;
  logic [15:0] total_length_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  untrusted_text_envelope_filter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .in_empty_i     (in_empty_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .out_last_o     (out_last_o),
    .total_length_o (total_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the filter
  logic [15:0] cap_shadow = 16'd4096;
  logic [7:0]  look_win [WIN_LEN];
  int          win_fill = 0;
  logic [15:0] out_count = 16'd0;
  bit          msg_open = 1'b0;
  bit          body_stop = 1'b0;
  int          step_words;

  env_word_t   expected_words [$];
  logic [7:0]  msg_q [$];

  int errors = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int msgs_sent = 0;
  int cap_writes = 0;
  int full_stalls = 0;
  bit idle_on = 1'b1;

  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;
  int pop_gap = 0;

  env_word_t got_word, want_word;

  function automatic void emit_word(input logic [7:0] b);
    expected_words.push_back('{data: b, valid: 1'b1, last: 1'b0, total: 16'h0000});
    step_words++;
    out_count++;
  endfunction

  function automatic void shift_window(input int n);
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i < win_fill - n; i++) look_win[i] = look_win[i + n];
      win_fill -= n;
    end
  endfunction

  function automatic bit is_hidden_seq();
    logic [7:0] a, b, c;
    a = look_win[0];
    b = look_win[1];
    c = look_win[2];
    if (a == 8'hE2 && b == 8'h80 && c >= 8'h8B && c <= 8'h8F) return 1'b1;
    if (a == 8'hE2 && b == 8'h80 && c >= 8'hAA && c <= 8'hAE) return 1'b1;
    if (a == 8'hE2 && b == 8'h81 && c >= 8'hA6 && c <= 8'hA9) return 1'b1;
    if (a == 8'hEF && b == 8'hBB && c == 8'hBF) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit head_is_needle();
    for (int i = 0; i < TAG_LEN; i++) begin
      if (look_win[i] != CLOSE_TEXT[8*(TAG_LEN-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void decide_head_byte();
    logic [7:0] c;
    if (!(int'(out_count) + 21 < int'(cap_shadow))) begin
      body_stop = 1'b1;
      win_fill = 0;
      return;
    end
    c = look_win[0];
    if (win_fill >= 3 && is_hidden_seq()) begin
      shift_window(3);
    end else if ((c < 8'h20 && c != CH_TAB && c != CH_LF) || c == CH_DEL) begin
      shift_window(1);
    end else if (win_fill >= TAG_LEN && head_is_needle()) begin
      emit_word(CH_BSLASH);
      emit_word(CH_AMP);
      shift_window(1);
    end else begin
      emit_word(c);
      shift_window(1);
    end
  endfunction

  function automatic void envelope_step(input logic [7:0] b, input logic last,
                                        input logic emp);
    step_words = 0;
    if (!msg_open) begin
      msg_open = 1'b1;
      if (int'(cap_shadow) < MIN_CAPACITY) body_stop = 1'b1;
      else for (int k = 0; k < TAG_LEN; k++) emit_word(OPEN_TEXT[8*(TAG_LEN-1-k) +: 8]);
    end
    if (!emp && !body_stop) begin
      if (win_fill < WIN_LEN) begin
        look_win[win_fill] = b;
        win_fill++;
      end
      if (win_fill >= WIN_LEN) decide_head_byte();
    end
    if (last || emp) begin
      while (win_fill > 0 && !body_stop) decide_head_byte();
      if (out_count != 0 && int'(out_count) + TAG_LEN + 1 < int'(cap_shadow)) begin
        emit_word(CH_LF);
        for (int k = 0; k < TAG_LEN; k++) emit_word(CLOSE_TEXT[8*(TAG_LEN-1-k) +: 8]);
      end
      if (step_words > 0) begin
        expected_words[expected_words.size()-1].last  = 1'b1;
        expected_words[expected_words.size()-1].total = out_count;
      end else begin
        expected_words.push_back('{data: 8'h00, valid: 1'b0, last: 1'b1, total: out_count});
      end
      win_fill  = 0;
      out_count = 16'd0;
      msg_open  = 1'b0;
      body_stop = 1'b0;
    end
  endfunction

  // result side: pop with random hold-offs, plus one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      pop <= 1'b0;
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
    end else if (pop_gap != 0) begin
      pop <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      pop_gap <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      got_word = '{data: out_byte_o, valid: out_valid_o, last: out_last_o,
                   total: total_length_o};
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected word: byte %02h valid %b last %b total %0d",
                   got_word.data, got_word.valid, got_word.last, got_word.total);
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.data !== want_word.data || got_word.valid !== want_word.valid ||
            got_word.last !== want_word.last || got_word.total !== want_word.total) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"mismatch at word %0d: exp byte %02h valid %b last %b total %0d,",
                      " got byte %02h valid %b last %b total %0d"},
                     words_checked, want_word.data, want_word.valid, want_word.last,
                     want_word.total, got_word.data, got_word.valid, got_word.last,
                     got_word.total);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last, input logic emp);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    in_empty_i <= emp;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    envelope_step(b, last, emp);
    words_sent++;
  endtask

  // sends msg_q; ends with a separate empty word if asked or if msg_q is empty
  task automatic send_message(input bit end_by_empty);
    for (int i = 0; i < msg_q.size(); i++)
      send_word(msg_q[i], (i == msg_q.size() - 1) && !end_by_empty, 1'b0);
    if (end_by_empty || msg_q.size() == 0)
      send_word(8'($urandom), 1'($urandom), 1'b1);
    msgs_sent++;
  endtask

  // block must be idle before a register write
  task automatic quiesce();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= {16'h0000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_shadow = v;
    cap_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("capacity read back: exp %0d got %0d", v, prdata[15:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_token();
    logic [7:0] third;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      4: begin
        // whole closing tag, or a prefix of it
        n = ($urandom_range(0, 1) == 0) ? TAG_LEN : $urandom_range(1, TAG_LEN - 1);
        for (int i = 0; i < n; i++) msg_q.push_back(CLOSE_TEXT[8*(TAG_LEN-1-i) +: 8]);
      end
      5: begin
        case ($urandom_range(0, 3))
          0: begin msg_q.push_back(8'hE2); msg_q.push_back(8'h80);
                   third = 8'($urandom_range(8'h8A, 8'h90)); end
          1: begin msg_q.push_back(8'hE2); msg_q.push_back(8'h80);
                   third = 8'($urandom_range(8'hA9, 8'hAF)); end
          2: begin msg_q.push_back(8'hE2); msg_q.push_back(8'h81);
                   third = 8'($urandom_range(8'hA5, 8'hAA)); end
          default: begin msg_q.push_back(8'hEF); msg_q.push_back(8'hBB);
                         third = 8'($urandom_range(8'hBE, 8'hC0)); end
        endcase
        msg_q.push_back(third);
      end
      6: msg_q.push_back(($urandom_range(0, 4) == 0) ? CH_DEL : 8'($urandom_range(0, 31)));
      default: msg_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  function automatic logic [15:0] pick_capacity();
    case ($urandom_range(0, 7))
      0: return 16'd64;
      1: return 16'($urandom_range(0, 63));
      2: return 16'hFFFF;
      3, 4: return 16'($urandom_range(65, 110));
      5: return 16'($urandom_range(111, 200));
      6: return 16'd4096;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---- tests ----

  task automatic empty_message_test();
    msg_q.delete();
    send_message(1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    msgs_sent++;
  endtask

  task automatic filter_test();
    msg_q = '{8'h00, CH_TAB, CH_LF, 8'h1F, CH_DEL, 8'hFF,
              8'hE2, 8'h80, 8'h8B, 8'hEF, 8'hBB, 8'hBF, 8'h20};
    send_message(1'b0);
  endtask

  task automatic mid_empty_test();
    msg_q = '{8'h41};
    send_message(1'b1);
  endtask

  task automatic null_message_test();
    write_capacity(16'd0);
    send_word(8'h80, 1'b1, 1'b0);
    write_capacity(16'd63);
    send_word(8'h78, 1'b0, 1'b0);
    // a raise in mid-message leaves it null
    write_capacity(16'hFFFF);
    send_word(8'h79, 1'b1, 1'b0);
    msgs_sent += 2;
  endtask

  task automatic random_traffic_test(input int budget);
    int start, target;
    bit by_empty;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(0, 3) == 0) write_capacity(pick_capacity());
      msg_q.delete();
      if ($urandom_range(0, 9) != 0) begin
        target = $urandom_range(1, 30);
        while (msg_q.size() < target) add_token();
        while (msg_q.size() > 40) void'(msg_q.pop_back());
      end
      by_empty = ($urandom_range(0, 6) == 0);
      send_message(by_empty);
    end
  endtask

  // long stall on the result side while a long message keeps coming
  task automatic hold_off_test();
    write_capacity(16'd4096);
    hold_req_cnt <= hold_req_cnt + 1;
    msg_q.delete();
    for (int i = 0; i < 50; i++) msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    send_message(1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    empty_message_test();
    filter_test();
    mid_empty_test();
    null_message_test();
    filter_test();
    random_traffic_test(80);
    hold_off_test();
    idle_on = 1'b0;
    random_traffic_test(30);

    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d messages, %0d input words, %0d result words checked",
             msgs_sent, words_sent, words_checked);
    $display("     %0d capacity writes, %0d cycles with input held off, %0d errors",
             cap_writes, full_stalls, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/uef_pkg.sv
hw/rtl/uef_front.sv
hw/rtl/uef_cmd_fifo.sv
hw/rtl/uef_back.sv
hw/rtl/untrusted_text_envelope_filter.sv
sim/tb_top.sv
